// ----- sv/tlbpt_pkg.sv -----
// tlbpt_pkg: shared constants and types for the page translate core
// no dependencies
`default_nettype none
package tlbpt_pkg;
  localparam int TlbEntries  = 16;
  localparam int FrameCount  = 256;
  localparam int PageCount   = 1024;
  localparam int OffsetWidth = 10;
  localparam int TlbIdxW     = $clog2(TlbEntries);
  localparam int FrameW      = $clog2(FrameCount);
  localparam int PageW       = $clog2(PageCount);
  localparam int AgeW        = FrameW;
  localparam int AddrW       = 20;
  localparam int PaddrW      = 18;

  // broadcast from the sequencer to the age cells
  typedef struct packed {
    logic              touch;
    logic [FrameW-1:0] frame;
    logic [AgeW-1:0]   ref_age;
  } age_bus_t;

  // per-cell report back to the sequencer
  typedef struct packed {
    logic            oldest;
    logic [AgeW-1:0] age;
  } age_rep_t;
endpackage
`default_nettype wire

// ----- sv/tlb_page_translate_fifo_lru_core.sv -----
// tlb_page_translate_fifo_lru_core: top level sequencer, tlb and age cell rows
// depends on tlbpt_pkg, tlbpt_ram, tlbpt_tlb_cell, tlbpt_age_cell
`default_nettype none
// Address translation with a 16-entry FIFO-filled TLB, a page map and frame
// replacement (round-robin or LRU, chosen by the policy bit).
// Usage: drive virt_addr with start high while busy is low; the beat is
// taken at that edge. One result beat follows with done high for exactly one
// cycle; the receiver cannot stall it. Accesses are taken one at a time.
// Sequence: on a TLB hit or page map hit done rises in the cycle after the
// accept edge (lookup state only); on a fault it rises after lookup, owner
// read, eviction of the old owner, page map and TLB fill.
// Back to back: a new beat can be taken in the cycle where done is high, so
// a new access is only taken once the previous one has finished.
// Configuration: cfg_valid/cfg_ready write the policy bit (cfg_data); ready only
// while idle with start low.
// Reset: after rst falls, a clearing pass walks all 1024 page map entries
// (which also covers the 256 owner entries), one per cycle, while busy stays
// high. Ages reset to 255 minus frame index, TLB invalid.
module tlb_page_translate_fifo_lru_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] virt_addr,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  output logic             done,
  output logic [17:0]      phys_addr,
  output logic             tlb_hit,
  output logic             page_fault,
  output logic             evicted,
  output logic [9:0]       evicted_page
);
  localparam int FW = tlbpt_pkg::FrameW;
  localparam int PW = tlbpt_pkg::PageW;
  localparam int TE = tlbpt_pkg::TlbEntries;
  localparam int FC = tlbpt_pkg::FrameCount;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_MAP   = 3'd3;
  localparam logic [2:0] S_OWN   = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;

  logic [2:0]  state;
  logic        policy;
  logic [PW-1:0] clr_cnt;
  logic [PW-1:0] page;
  logic [tlbpt_pkg::OffsetWidth-1:0] offset;
  logic [FW-1:0] frame;
  logic        hit_r, fault_r, ev_r;
  logic [PW-1:0] ev_pg;
  logic [tlbpt_pkg::TlbIdxW-1:0] slot;
  logic [FW-1:0] fifo_ptr;

  // ram ports
  logic          pm_we;
  logic [PW-1:0] pm_addr;
  logic [FW:0]   pm_wdata, pm_rdata;
  logic          ow_we;
  logic [FW-1:0] ow_addr;
  logic [PW:0]   ow_wdata, ow_rdata;

  // tlb row
  logic [TE-1:0]   t_hit;
  logic [FW-1:0]   t_frame [TE];
  logic            t_wr;
  logic [FW-1:0]   t_wframe;
  logic            t_drop;
  logic [FW-1:0]   t_any_frame;
  logic            t_any;

  // age row
  tlbpt_pkg::age_bus_t abus;
  tlbpt_pkg::age_rep_t arep [FC];
  logic [FW-1:0]       oldest_idx;
  logic [tlbpt_pkg::AgeW-1:0] sel_age;

  tlbpt_ram #(.Width(FW + 1), .Depth(tlbpt_pkg::PageCount)) u_page_map (
    .clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata)
  );
  tlbpt_ram #(.Width(PW + 1), .Depth(FC)) u_owner (
    .clk(clk), .we(ow_we), .addr(ow_addr), .wdata(ow_wdata), .rdata(ow_rdata)
  );

  for (genvar i = 0; i < TE; i++) begin : g_tlb
    tlbpt_tlb_cell u_cell (
      .clk(clk), .rst(rst),
      .wr(t_wr && slot == tlbpt_pkg::TlbIdxW'(i)),
      .drop(t_drop), .drop_frame(frame),
      .page(page), .wframe(t_wframe),
      .hit(t_hit[i]), .frame(t_frame[i])
    );
  end

  for (genvar i = 0; i < FC; i++) begin : g_age
    tlbpt_age_cell u_cell (
      .clk(clk), .rst(rst), .index(FW'(i)), .bus(abus), .rep(arep[i])
    );
  end

  // lowest matching tlb slot
  always_comb begin
    t_any = 1'b0;
    t_any_frame = '0;
    for (int i = TE - 1; i >= 0; i--) begin
      if (t_hit[i]) begin
        t_any = 1'b1;
        t_any_frame = t_frame[i];
      end
    end
  end

  // oldest frame select (ages are a permutation, one match)
  always_comb begin
    oldest_idx = '0;
    for (int i = 0; i < FC; i++) begin
      if (arep[i].oldest) oldest_idx = oldest_idx | FW'(i);
    end
  end

  // age of touched frame, read from a register
  logic [FW-1:0] touch_frame_sel;
  always_comb sel_age = arep[touch_frame_sel].age;

  // ram and row controls
  always_comb begin
    pm_we = 1'b0; pm_addr = page; pm_wdata = '0;
    ow_we = 1'b0; ow_addr = frame; ow_wdata = '0;
    t_wr = 1'b0; t_drop = 1'b0; t_wframe = frame;
    abus.touch = 1'b0; abus.frame = frame; abus.ref_age = sel_age;
    touch_frame_sel = frame;
    case (state)
      S_CLEAR: begin
        pm_we = 1'b1; pm_addr = clr_cnt;
        ow_we = 1'b1; ow_addr = clr_cnt[FW-1:0];
      end
      S_IDLE: pm_addr = virt_addr[tlbpt_pkg::OffsetWidth +: PW];
      S_LOOK: begin
        if (t_any) begin
          abus.touch = 1'b1; abus.frame = t_any_frame;
          touch_frame_sel = t_any_frame;
        end else if (pm_rdata[FW]) begin
          // page map hit: tlb takes the frame straight from the ram
          t_wr = 1'b1; t_wframe = pm_rdata[FW-1:0]; abus.touch = 1'b1;
          abus.frame = pm_rdata[FW-1:0];
          touch_frame_sel = pm_rdata[FW-1:0];
        end
      end
      S_OWN: begin
        // owner read is registered; old page entry cleared next cycle
      end
      S_FILL: begin
        if (ow_rdata[PW]) begin
          pm_we = 1'b1; pm_addr = ow_rdata[PW-1:0]; t_drop = 1'b1;
        end
        ow_we = 1'b1; ow_wdata = {1'b1, page};
      end
      S_MAP: begin
        pm_we = 1'b1; pm_wdata = {1'b1, frame};
        t_wr = 1'b1; abus.touch = 1'b1;
      end
      default: ;
    endcase
  end

  // frame read from the page map on a page map hit
  logic [FW-1:0] wfr;
  assign wfr = pm_rdata[FW-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; policy <= 1'b0;
      slot <= '0; fifo_ptr <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) policy <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          page   <= virt_addr[tlbpt_pkg::OffsetWidth +: PW];
          offset <= virt_addr[tlbpt_pkg::OffsetWidth-1:0];
          state  <= S_LOOK;
        end
        S_LOOK: begin
          hit_r <= t_any; fault_r <= 1'b0; ev_r <= 1'b0; ev_pg <= '0;
          if (t_any) begin
            frame <= t_any_frame; state <= S_IDLE; done <= 1'b1;
          end else if (pm_rdata[FW]) begin
            frame <= wfr; slot <= slot + 1'b1;
            state <= S_IDLE; done <= 1'b1;
          end else begin
            fault_r <= 1'b1;
            if (policy) frame <= oldest_idx;
            else begin
              frame <= fifo_ptr; fifo_ptr <= fifo_ptr + 1'b1;
            end
            state <= S_OWN;
          end
        end
        S_OWN: state <= S_FILL;
        S_FILL: begin
          ev_r <= ow_rdata[PW];
          ev_pg <= ow_rdata[PW] ? ow_rdata[PW-1:0] : '0;
          state <= S_MAP;
        end
        S_MAP: begin
          slot <= slot + 1'b1; state <= S_IDLE; done <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign phys_addr = 18'({frame, offset});
  assign tlb_hit = hit_r;
  assign page_fault = fault_r;
  assign evicted = ev_r;
  assign evicted_page = ev_pg;
endmodule
`default_nettype wire

// ----- sv/tlbpt_ram.sv -----
// tlbpt_ram: generic single port ram with registered read
// no dependencies
`default_nettype none
module tlbpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- sv/tlbpt_age_cell.sv -----
// tlbpt_age_cell: one lru age register, updated on touch broadcast
// depends on tlbpt_pkg
`default_nettype none
module tlbpt_age_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [tlbpt_pkg::FrameW-1:0] index,
  input  wire tlbpt_pkg::age_bus_t          bus,
  output tlbpt_pkg::age_rep_t               rep
);
  logic [tlbpt_pkg::AgeW-1:0] age;

  // age update: chosen frame to zero, younger ones age by one
  always_ff @(posedge clk) begin
    if (rst) begin
      age <= tlbpt_pkg::AgeW'(tlbpt_pkg::FrameCount - 1) - index;
    end else if (bus.touch) begin
      if (index == bus.frame) age <= '0;
      else if (age < bus.ref_age) age <= age + 1'b1;
    end
  end

  assign rep.age    = age;
  assign rep.oldest = (age == tlbpt_pkg::AgeW'(tlbpt_pkg::FrameCount - 1));
endmodule
`default_nettype wire

// ----- sv/tlbpt_tlb_cell.sv -----
// tlbpt_tlb_cell: one tlb entry with tag compare and frame drop
// depends on tlbpt_pkg
`default_nettype none
module tlbpt_tlb_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr,
  input  wire logic                         drop,
  input  wire logic [tlbpt_pkg::FrameW-1:0] drop_frame,
  input  wire logic [tlbpt_pkg::PageW-1:0]  page,
  input  wire logic [tlbpt_pkg::FrameW-1:0] wframe,
  output logic                              hit,
  output logic      [tlbpt_pkg::FrameW-1:0] frame
);
  logic                         valid;
  logic [tlbpt_pkg::PageW-1:0]  tag;

  // entry storage; a write wins over a drop in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tag   <= '0;
      frame <= '0;
    end else if (wr) begin
      valid <= 1'b1;
      tag   <= page;
      frame <= wframe;
    end else if (drop && valid && frame == drop_frame) begin
      valid <= 1'b0;
    end
  end

  assign hit = valid && (tag == page);
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for tlb_page_translate_fifo_lru_core
// depends on tlbpt_pkg and the core rtl; translation predicted in-bench
`default_nettype none
module tb;
  localparam int PaddrW      = tlbpt_pkg::PaddrW;
  localparam int PageW       = tlbpt_pkg::PageW;
  localparam int FrameW      = tlbpt_pkg::FrameW;
  localparam int AgeW        = tlbpt_pkg::AgeW;
  localparam int AddrW       = tlbpt_pkg::AddrW;
  localparam int TlbIdxW     = tlbpt_pkg::TlbIdxW;
  localparam int PageCount   = tlbpt_pkg::PageCount;
  localparam int FrameCount  = tlbpt_pkg::FrameCount;
  localparam int TlbEntries  = tlbpt_pkg::TlbEntries;
  localparam int OffsetWidth = tlbpt_pkg::OffsetWidth;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [PaddrW-1:0] paddr;
    logic              hit;
    logic              fault;
    logic              ev;
    logic [PageW-1:0]  ev_page;
  } xlat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [AddrW-1:0]  virt_addr = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_data = 1'b0;
  logic              busy, cfg_ready, done;
  logic [PaddrW-1:0] phys_addr;
  logic              tlb_hit, page_fault, evicted;
  logic [PageW-1:0]  evicted_page;

  tlb_page_translate_fifo_lru_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .virt_addr(virt_addr), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .phys_addr(phys_addr), .tlb_hit(tlb_hit),
    .page_fault(page_fault), .evicted(evicted), .evicted_page(evicted_page)
  );

  always #5 clk = ~clk;

  // translation state mirror
  logic               lru_mode;
  logic               pm_valid [PageCount];
  logic [FrameW-1:0]  pm_frame [PageCount];
  logic               own_valid [FrameCount];
  logic [PageW-1:0]   own_page [FrameCount];
  logic [AgeW-1:0]    age [FrameCount];
  logic [PageW-1:0]   tl_tag [TlbEntries];
  logic [FrameW-1:0]  tl_frame [TlbEntries];
  logic               tl_valid [TlbEntries];
  logic [TlbIdxW-1:0] tl_next;
  logic [FrameW-1:0]  rr_next;

  xlat_t pending_xlat[$];
  int    err_cnt = 0;
  int    cycles = 0;

  task automatic mirror_reset();
    lru_mode = 1'b0;
    for (int i = 0; i < PageCount; i++) begin
      pm_valid[i] = 1'b0; pm_frame[i] = '0;
    end
    for (int i = 0; i < FrameCount; i++) begin
      own_valid[i] = 1'b0; own_page[i] = '0; age[i] = AgeW'(FrameCount - 1 - i);
    end
    for (int i = 0; i < TlbEntries; i++) begin
      tl_tag[i] = '0; tl_frame[i] = '0; tl_valid[i] = 1'b0;
    end
    tl_next = '0;
    rr_next = '0;
  endtask

  function automatic xlat_t translate(logic [AddrW-1:0] la);
    xlat_t r;
    logic [PageW-1:0] pg;
    logic [FrameW-1:0] fr;
    logic [AgeW-1:0] a;
    pg = la[AddrW-1:OffsetWidth];
    r = '0;
    fr = '0;
    for (int i = 0; i < TlbEntries; i++)
      if (!r.hit && tl_valid[i] && tl_tag[i] == pg) begin
        r.hit = 1'b1; fr = tl_frame[i];
      end
    if (!r.hit) begin
      if (pm_valid[pg]) fr = pm_frame[pg];
      else begin
        r.fault = 1'b1;
        if (lru_mode) begin
          for (int i = FrameCount - 1; i >= 0; i--)
            if (age[i] == AgeW'(FrameCount - 1)) fr = FrameW'(i);
        end else begin
          fr = rr_next;
          rr_next = rr_next + 1'b1;
        end
        // evict previous owner and its tlb entries
        if (own_valid[fr]) begin
          r.ev = 1'b1;
          r.ev_page = own_page[fr];
          pm_valid[own_page[fr]] = 1'b0;
          for (int i = 0; i < TlbEntries; i++)
            if (tl_valid[i] && tl_frame[i] == fr) tl_valid[i] = 1'b0;
        end
        own_valid[fr] = 1'b1; own_page[fr] = pg;
        pm_valid[pg] = 1'b1; pm_frame[pg] = fr;
      end
      tl_tag[tl_next] = pg; tl_frame[tl_next] = fr; tl_valid[tl_next] = 1'b1;
      tl_next = tl_next + 1'b1;
    end
    a = age[fr];
    for (int i = 0; i < FrameCount; i++)
      if (i == fr) age[i] = '0;
      else if (age[i] < a) age[i] = age[i] + 1'b1;
    r.paddr = {fr, la[OffsetWidth-1:0]};
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    xlat_t e;
    if (!rst && done) begin
      if (pending_xlat.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        e = pending_xlat.pop_front();
        if (phys_addr !== e.paddr) begin
          $error("phys_addr exp %h got %h", e.paddr, phys_addr); err_cnt++;
        end
        if (tlb_hit !== e.hit) begin
          $error("tlb_hit exp %b got %b", e.hit, tlb_hit); err_cnt++;
        end
        if (page_fault !== e.fault) begin
          $error("page_fault exp %b got %b", e.fault, page_fault); err_cnt++;
        end
        if (evicted !== e.ev) begin
          $error("evicted exp %b got %b", e.ev, evicted); err_cnt++;
        end
        if (evicted_page !== e.ev_page) begin
          $error("evicted_page exp %h got %h", e.ev_page, evicted_page); err_cnt++;
        end
      end
    end
  end

  // one access beat, with a random gap in front
  task automatic send_access(logic [AddrW-1:0] la, bit gap = 1);
    if (gap) repeat ($urandom_range(0, 7)) @(negedge clk);
    start = 1'b1;
    virt_addr = la;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_xlat.push_back(translate(la));
    @(negedge clk);
    start = 1'b0;
    virt_addr = AddrW'($urandom);
  endtask

  task automatic drain();
    while (pending_xlat.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_policy(logic pol);
    drain();
    cfg_valid = 1'b1;
    cfg_data = pol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lru_mode = pol;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // corner addresses, tlb hits and page map hits
  task automatic test_directed();
    send_access('0);
    send_access('0);
    send_access(20'hFFFFF);
    send_access(20'hFFC00);
    send_access(20'h003FF);
    send_access(20'hAAAAA);
    send_access(20'h55555);
    for (int i = 1; i <= 17; i++) send_access(AddrW'(i << OffsetWidth));
    send_access(20'h00400); // evicted from tlb, still in page map
  endtask

  // pages beyond frame count force round-robin eviction
  task automatic test_fifo_evict();
    for (int i = 0; i < 300; i++)
      send_access({PageW'($urandom_range(0, 399)), OffsetWidth'($urandom)}, i % 3 == 0);
  endtask

  // lru with a hot working set mixed with new pages
  task automatic test_lru();
    for (int i = 0; i < 400; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_access({PageW'($urandom_range(0, 15)), OffsetWidth'($urandom)}, i % 4 != 0);
      else
        send_access({PageW'($urandom), OffsetWidth'($urandom)}, i % 4 != 0);
    end
  endtask

  // policy switching between drained bursts of accesses
  task automatic test_switch();
    for (int k = 0; k < 6; k++) begin
      set_policy(k[0]);
      for (int i = 0; i < 50; i++)
        send_access({PageW'($urandom_range(0, 299)), OffsetWidth'($urandom)});
    end
  endtask

  initial begin
    mirror_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fifo_evict();
    set_policy(1'b1);
    test_lru();
    test_switch();
    drain();
    if (err_cnt == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/tlbpt_pkg.sv
sv/tlbpt_ram.sv
sv/tlbpt_age_cell.sv
sv/tlbpt_tlb_cell.sv
sv/tlb_page_translate_fifo_lru_core.sv
bench/tb.sv
